// ----- src/assert_macros.svh -----
// Assertion macros used by the allocator RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define STW_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define STW_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define STW_ASSERT(label, clk, rstn, prop, msg)
`define STW_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ----- src/stwa_pkg.sv -----
// Types and constants of the spectrum/time window allocator
`timescale 1ns / 1ps
`default_nettype none
package stwa_pkg;
    localparam int TW   = 7;   // time counters, up to 64
    localparam int RUNW = 7;   // spectrum run length, up to 64

    localparam logic [2:0] REG_ARRIVAL  = 3'd0;
    localparam logic [2:0] REG_DEADLINE = 3'd1;
    localparam logic [2:0] REG_CAPACITY = 3'd2;
    localparam logic [2:0] REG_GUARD    = 3'd3;
    localparam logic [2:0] REG_POLICY   = 3'd4;

    typedef struct packed {
        logic [5:0]  time_index;
        logic [63:0] link_mask;
        logic        last_of_path;
        logic        last_of_request;
    } t_in_item;

    typedef struct packed {
        logic       found;
        logic [2:0] sel_path;
        logic [5:0] win_start;
        logic [5:0] win_end;
        logic [5:0] first_slot;
        logic [5:0] last_slot;
    } t_res_item;

    typedef struct packed {
        logic clr;
        logic step;
    } t_fit_ctl;

    typedef struct packed {
        logic            hit;
        logic            last;
        logic [RUNW-1:0] need;
        logic [5:0]      first;
    } t_fit_sts;
endpackage
`default_nettype wire

// ----- src/spectrum_time_window_allocator_unit.sv -----
// Top level of the spectrum/time window allocator
//
//  channel | signals                                   | handshake
//  --------+-------------------------------------------+------------------------------
//  item in | i_item (t_in_item)                        | start & !busy
//  result  | o_res (t_res_item)                        | o_res_vld, one cycle, no stall
//  config  | psel penable pwrite paddr pwdata prdata   | APB write, pready tied high
//
// A mask item passes through accept, store read and store write.
// An item that ends a path adds the window search: an init step per end e; for
// each start s a store read, an AND step and up to SPECTRUM_SLOTS bits in the fit
// scanner; key, update and finish steps to score the path; a refill of TIME_SLOTS rows.
// The fit scanner (one run counter, one small multiply-compare) sets the rate.
// Reset: synchronous, active low; after it the store is swept to all ones, row by
// row with busy high (config writes are still taken).
// The result receiver cannot stall; o_res_vld is high for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module spectrum_time_window_allocator_unit import stwa_pkg::*; #(
    parameter int SPECTRUM_SLOTS = 64,
    parameter int TIME_SLOTS     = 64,
    parameter int MAX_PATHS      = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire t_in_item    i_item,
    output logic             o_res_vld,
    output t_res_item        o_res,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam int AW  = $clog2(TIME_SLOTS);
    localparam int PCW = $clog2(MAX_PATHS + 1);

    typedef enum logic [10:0] {
        S_CLR   = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_LDRD  = 11'b00000000100,
        S_LDWR  = 11'b00000001000,
        S_EINIT = 11'b00000010000,
        S_SRD   = 11'b00000100000,
        S_SAND  = 11'b00001000000,
        S_SCAN  = 11'b00010000000,
        S_KEY   = 11'b00100000000,
        S_UPD   = 11'b01000000000,
        S_FIN   = 11'b10000000000
    } t_state;

    t_state r_state;

    // config registers
    logic [5:0]  r_arrival;
    logic [6:0]  r_deadline;
    logic [11:0] r_capacity;
    logic [5:0]  r_guard;
    logic        r_policy;

    // latched item and search state
    t_in_item                r_item;
    logic [AW-1:0]           r_clr;
    logic [TW-1:0]           r_e, r_s;
    logic [SPECTRUM_SLOTS-1:0] r_acc;
    logic                    r_hit;
    logic [TW-1:0]           r_bs, r_be;
    logic [5:0]              r_bf;
    logic [RUNW-1:0]         r_bn;
    logic [12:0]             r_key;

    // per-request best
    logic [PCW-1:0]          r_pcnt;
    logic                    r_have;
    logic [12:0]             r_best_key;
    logic [2:0]              r_best_path;
    logic [5:0]              r_best_s, r_best_e, r_best_f, r_best_l;

    // store and fit unit wiring
    logic                      st_we;
    logic [AW-1:0]             st_waddr, st_raddr;
    logic [SPECTRUM_SLOTS-1:0] st_wdata, st_rdata;
    t_fit_ctl                  fit_ctl;
    t_fit_sts                  fit_sts;
    logic [TW-1:0]             len;
    logic [TW-1:0]             dl;
    logic                      t_ok, end_path;
    logic [TW-1:0]             len_b;
    logic [14:0]               area;
    logic                      cfg_wr;

    assign busy   = (r_state != S_IDLE);
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    assign dl       = (32'(r_deadline) > TIME_SLOTS) ? TW'(TIME_SLOTS) : r_deadline;
    assign t_ok     = (32'(r_item.time_index) < TIME_SLOTS);
    assign end_path = r_item.last_of_path || r_item.last_of_request;
    assign len      = r_e - r_s;
    assign len_b    = r_be - r_bs;
    assign area     = len_b * (8'(r_bn) + 8'(r_guard));

    always_comb begin
        st_we    = 1'b0;
        st_waddr = r_clr;
        st_wdata = '1;
        st_raddr = '0;
        fit_ctl  = '0;
        case (r_state)
            S_CLR: begin
                st_we = 1'b1;
            end
            S_LDRD: begin
                st_raddr = AW'(r_item.time_index);
            end
            S_LDWR: begin
                st_we    = t_ok;
                st_waddr = AW'(r_item.time_index);
                st_wdata = st_rdata & r_item.link_mask[SPECTRUM_SLOTS-1:0];
            end
            S_SRD: begin
                st_raddr = AW'(r_s - TW'(1));
            end
            S_SAND: begin
                fit_ctl.clr = 1'b1;
            end
            S_SCAN: begin
                fit_ctl.step = 1'b1;
            end
            default: begin
            end
        endcase
    end

    stwa_store #(
        .DEPTH (TIME_SLOTS),
        .WIDTH (SPECTRUM_SLOTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    stwa_fit #(
        .SPECTRUM_SLOTS (SPECTRUM_SLOTS)
    ) u_fit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (fit_ctl),
        .i_acc   (r_acc),
        .i_len   (len),
        .i_cap   (r_capacity),
        .o_sts   (fit_sts)
    );

    // configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arrival  <= '0;
            r_deadline <= '0;
            r_capacity <= 12'd1;
            r_guard    <= '0;
            r_policy   <= 1'b0;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_ARRIVAL:  r_arrival  <= pwdata[5:0];
                REG_DEADLINE: r_deadline <= pwdata[6:0];
                REG_CAPACITY: r_capacity <= pwdata[11:0];
                REG_GUARD:    r_guard    <= pwdata[5:0];
                REG_POLICY:   r_policy   <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_ARRIVAL:  prdata = 32'(r_arrival);
            REG_DEADLINE: prdata = 32'(r_deadline);
            REG_CAPACITY: prdata = 32'(r_capacity);
            REG_GUARD:    prdata = 32'(r_guard);
            REG_POLICY:   prdata = 32'(r_policy);
            default:      prdata = '0;
        endcase
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_item <= i_item;
        end
        case (r_state)
            S_EINIT: begin
                r_acc <= '1;
                r_s   <= r_e;
            end
            S_SRD: begin
                if (r_s != TW'(r_arrival)) begin
                    r_s <= r_s - TW'(1);
                end
            end
            S_SAND: begin
                r_acc <= r_acc & st_rdata;
            end
            S_SCAN: begin
                // keep overwriting: the last hit is the smallest start
                if (fit_sts.hit) begin
                    r_bs <= r_s;
                    r_be <= r_e;
                    r_bf <= fit_sts.first;
                    r_bn <= fit_sts.need;
                end
            end
            S_KEY: begin
                r_key <= r_policy ? area[12:0] : 13'(r_be);
            end
            default: begin
            end
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_e         <= '0;
            r_hit       <= 1'b0;
            r_pcnt      <= '0;
            r_have      <= 1'b0;
            r_best_key  <= '0;
            r_best_path <= '0;
            r_best_s    <= '0;
            r_best_e    <= '0;
            r_best_f    <= '0;
            r_best_l    <= '0;
            o_res_vld   <= 1'b0;
            o_res       <= '0;
        end else begin
            o_res_vld <= 1'b0;
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(TIME_SLOTS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_state <= S_LDRD;
                    end
                end
                S_LDRD: begin
                    r_state <= S_LDWR;
                end
                S_LDWR: begin
                    if (!end_path) begin
                        r_state <= S_IDLE;
                    end else if (32'(r_pcnt) < MAX_PATHS) begin
                        r_e     <= TW'(r_arrival) + TW'(1);
                        r_state <= S_EINIT;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_EINIT: begin
                    r_hit <= 1'b0;
                    if (r_e >= dl) begin
                        r_state <= S_FIN;   // no window on this path
                    end else begin
                        r_state <= S_SRD;
                    end
                end
                S_SRD: begin
                    if (r_s == TW'(r_arrival)) begin
                        if (r_hit) begin
                            r_state <= S_KEY;
                        end else begin
                            r_e     <= r_e + TW'(1);
                            r_state <= S_EINIT;
                        end
                    end else begin
                        r_state <= S_SAND;
                    end
                end
                S_SAND: begin
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (fit_sts.hit) begin
                        r_hit   <= 1'b1;
                        r_state <= S_SRD;
                    end else if (fit_sts.last) begin
                        r_state <= S_SRD;
                    end
                end
                S_KEY: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (!r_have || r_key < r_best_key) begin
                        r_have      <= 1'b1;
                        r_best_key  <= r_key;
                        r_best_path <= 3'(r_pcnt);
                        r_best_s    <= r_bs[5:0];
                        r_best_e    <= 6'(r_be - TW'(1));
                        r_best_f    <= r_bf;
                        r_best_l    <= 6'(7'(r_bf) + r_bn - 7'd1);
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (r_item.last_of_request) begin
                        o_res_vld <= 1'b1;
                        if (r_have) begin
                            o_res.found      <= 1'b1;
                            o_res.sel_path   <= r_best_path;
                            o_res.win_start  <= r_best_s;
                            o_res.win_end    <= r_best_e;
                            o_res.first_slot <= r_best_f;
                            o_res.last_slot  <= r_best_l;
                        end else begin
                            o_res <= '0;
                        end
                        r_pcnt      <= '0;
                        r_have      <= 1'b0;
                        r_best_key  <= '0;
                        r_best_path <= '0;
                        r_best_s    <= '0;
                        r_best_e    <= '0;
                        r_best_f    <= '0;
                        r_best_l    <= '0;
                    end else if (32'(r_pcnt) < MAX_PATHS) begin
                        r_pcnt <= r_pcnt + PCW'(1);
                    end
                    // refill the store after every path
                    r_clr   <= '0;
                    r_state <= S_CLR;
                end
                default: begin
                    r_state <= S_CLR;
                    r_clr   <= '0;
                end
            endcase
        end
    end

    `STW_ASSERT(a_res_one_cycle, i_clk, i_rst_n, o_res_vld |=> !o_res_vld, "result strobe held")
    `STW_ASSERT(a_res_from_fin, i_clk, i_rst_n, o_res_vld |-> $past(r_state == S_FIN), "stray result")
    `STW_ASSERT(a_accept_busy, i_clk, i_rst_n, (start && !busy) |=> busy, "busy not raised")
    `STW_ASSERT(a_scan_window, i_clk, i_rst_n, (r_state == S_SCAN) |-> (r_e > r_s), "empty window scanned")
endmodule
`default_nettype wire

// ----- src/stwa_store.sv -----
// Time mask store: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none
module stwa_store #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- src/stwa_fit.sv -----
// Bit-serial first-fit scanner with run-length times window-length check
`timescale 1ns / 1ps
`default_nettype none
module stwa_fit import stwa_pkg::*; #(
    parameter int SPECTRUM_SLOTS = 64
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire t_fit_ctl                  i_ctl,
    input  wire logic [SPECTRUM_SLOTS-1:0] i_acc,
    input  wire logic [TW-1:0]             i_len,
    input  wire logic [11:0]               i_cap,
    output t_fit_sts                       o_sts
);
    localparam int IW = (SPECTRUM_SLOTS > 1) ? $clog2(SPECTRUM_SLOTS) : 1;

    logic [IW-1:0]        r_idx;
    logic [RUNW-1:0]      r_run;
    logic [RUNW-1:0]      run_new;
    logic                 bit_free;
    logic [11:0]          cap_eff;
    logic [RUNW+TW-1:0]   prod;
    logic [RUNW-1:0]      first_w;

    always_comb begin
        bit_free = i_acc[r_idx];
        run_new  = bit_free ? r_run + RUNW'(1) : '0;
        cap_eff  = (i_cap == 12'd0) ? 12'd1 : i_cap;
        // run * len >= cap  <=>  run >= ceil(cap / len)
        prod     = run_new * i_len;
        first_w  = RUNW'(r_idx) + RUNW'(1) - run_new;
        o_sts.hit   = i_ctl.step && bit_free && (prod >= (RUNW+TW)'(cap_eff));
        o_sts.last  = (r_idx == IW'(SPECTRUM_SLOTS - 1));
        o_sts.need  = run_new;
        o_sts.first = first_w[5:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_run <= '0;
        end else if (i_ctl.clr) begin
            r_idx <= '0;
            r_run <= '0;
        end else if (i_ctl.step) begin
            r_idx <= r_idx + IW'(1);
            r_run <= run_new;
        end
    end
endmodule
`default_nettype wire
